>>> hw/rtl/dmdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmdr_pkg;

    // Command codes carried in the func field of an input item.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SPEED = 2'd1,
        FUNC_DIR   = 2'd2,
        FUNC_POWER = 2'd3
    } t_func;

    // Speed level codes.
    localparam logic [1:0] SPEED_SLOW   = 2'd0;
    localparam logic [1:0] SPEED_MIDDLE = 2'd1;
    localparam logic [1:0] SPEED_FAST   = 2'd2;
    localparam logic [1:0] SPEED_KEEP   = 2'd3;

    // Drive direction codes.
    localparam logic [3:0] DIR_STOP       = 4'd0;
    localparam logic [3:0] DIR_FWD        = 4'd1;
    localparam logic [3:0] DIR_BACK       = 4'd2;
    localparam logic [3:0] DIR_LEFT       = 4'd3;
    localparam logic [3:0] DIR_RIGHT      = 4'd4;
    localparam logic [3:0] DIR_FWD_RIGHT  = 4'd5;
    localparam logic [3:0] DIR_FWD_LEFT   = 4'd6;
    localparam logic [3:0] DIR_BACK_RIGHT = 4'd7;
    localparam logic [3:0] DIR_BACK_LEFT  = 4'd8;

    localparam logic [3:0] POWER_ON = 4'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST   = 2'd2;

    localparam int SLOW_RESET   = 3276;
    localparam int MIDDLE_RESET = 5733;
    localparam int FAST_RESET   = 8190;

    // Channel numbering.
    localparam int NCHAN     = 4;
    localparam int CH_FWD_A  = 0;
    localparam int CH_FWD_B  = 1;
    localparam int CH_BACK_A = 2;
    localparam int CH_BACK_B = 3;

    // Division by ten: (x * 52429) >> 19 is exact for every 16-bit x.
    localparam int               DIV_IN_BITS  = 16;
    localparam int               DIV_MUL_BITS = 17;
    localparam logic [16:0]      DIV10_MUL    = 17'd52429;
    localparam int               DIV10_SHIFT  = 19;

    // Per-tick control handed to every channel.
    typedef struct packed {
        logic retarget;
        logic active;
    } t_chan_ctrl;

endpackage

`default_nettype wire

>>> hw/rtl/dmdr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dmdr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface dmdr_out_if #(
    parameter int DUTY_BITS = 13
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_fwd_a;
    logic [DUTY_BITS-1:0] duty_fwd_b;
    logic [DUTY_BITS-1:0] duty_back_a;
    logic [DUTY_BITS-1:0] duty_back_b;
    logic                 busy_ramping;
    logic [3:0]           drive_direction;
    logic [1:0]           level_now;
    logic                 is_on;

    modport source (
        output valid, output duty_fwd_a, output duty_fwd_b, output duty_back_a,
        output duty_back_b, output busy_ramping, output drive_direction,
        output level_now, output is_on, input ready
    );
    modport sink (
        input valid, input duty_fwd_a, input duty_fwd_b, input duty_back_a,
        input duty_back_b, input busy_ramping, input drive_direction,
        input level_now, input is_on, output ready
    );
endinterface

interface dmdr_cfg_if #(
    parameter int DUTY_BITS = 13
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           index;
    logic [DUTY_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dmdr_target.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps direction and level duty to the four channel targets.
module dmdr_target #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic                 i_run,
    input  wire logic [3:0]           i_dir,
    input  wire logic [DUTY_BITS-1:0] i_level_duty,
    output logic      [DUTY_BITS-1:0] o_tgt [dmdr_pkg::NCHAN]
);

    logic [DUTY_BITS-1:0] full_d;
    logic [DUTY_BITS-1:0] half_d;
    logic [DUTY_BITS-1:0] t [dmdr_pkg::NCHAN];

    assign full_d = i_level_duty;
    assign half_d = i_level_duty >> 1;

    always_comb begin
        for (int i = 0; i < dmdr_pkg::NCHAN; i++) begin
            t[i] = '0;
        end
        case (i_dir)
            dmdr_pkg::DIR_FWD: begin
                t[dmdr_pkg::CH_FWD_A] = full_d;
                t[dmdr_pkg::CH_FWD_B] = full_d;
            end
            dmdr_pkg::DIR_BACK: begin
                t[dmdr_pkg::CH_BACK_A] = full_d;
                t[dmdr_pkg::CH_BACK_B] = full_d;
            end
            dmdr_pkg::DIR_LEFT: begin
                t[dmdr_pkg::CH_FWD_A] = full_d;
            end
            dmdr_pkg::DIR_RIGHT: begin
                t[dmdr_pkg::CH_FWD_B] = full_d;
            end
            dmdr_pkg::DIR_FWD_RIGHT: begin
                t[dmdr_pkg::CH_FWD_A] = half_d;
                t[dmdr_pkg::CH_FWD_B] = full_d;
            end
            dmdr_pkg::DIR_FWD_LEFT: begin
                t[dmdr_pkg::CH_FWD_A] = full_d;
                t[dmdr_pkg::CH_FWD_B] = half_d;
            end
            dmdr_pkg::DIR_BACK_RIGHT: begin
                t[dmdr_pkg::CH_BACK_A] = half_d;
                t[dmdr_pkg::CH_BACK_B] = full_d;
            end
            dmdr_pkg::DIR_BACK_LEFT: begin
                t[dmdr_pkg::CH_BACK_A] = full_d;
                t[dmdr_pkg::CH_BACK_B] = half_d;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < dmdr_pkg::NCHAN; i++) begin
            o_tgt[i] = i_run ? t[i] : '0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dmdr_chan.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel's ramp step: new step size on retarget, then one move.
module dmdr_chan #(
    parameter int DUTY_BITS = 13
) (
    input  wire dmdr_pkg::t_chan_ctrl  i_ctrl,
    input  wire logic [DUTY_BITS-1:0]  i_cur,
    input  wire logic [DUTY_BITS-1:0]  i_tgt,
    input  wire logic [DUTY_BITS-1:0]  i_step,
    output logic      [DUTY_BITS-1:0]  o_cur,
    output logic      [DUTY_BITS-1:0]  o_step,
    output logic                       o_moved
);

    localparam int PROD_BITS = dmdr_pkg::DIV_IN_BITS + dmdr_pkg::DIV_MUL_BITS;

    logic                 above;
    logic                 below;
    logic [DUTY_BITS-1:0] span;
    logic [PROD_BITS-1:0] prod;
    logic [DUTY_BITS-1:0] quot;
    logic [DUTY_BITS-1:0] step_new;
    logic [DUTY_BITS-1:0] s;
    logic [DUTY_BITS:0]   twice_s;
    logic                 snap;

    assign above = i_cur > i_tgt;
    assign below = i_cur < i_tgt;
    assign span  = above ? (i_cur - i_tgt) : (i_tgt - i_cur);

    assign prod = PROD_BITS'(dmdr_pkg::DIV_IN_BITS'(span)) * PROD_BITS'(dmdr_pkg::DIV10_MUL);
    assign quot = DUTY_BITS'(prod >> dmdr_pkg::DIV10_SHIFT);

    always_comb begin
        if (!above && !below) begin
            step_new = '0;
        end else if (quot == '0) begin
            step_new = DUTY_BITS'(1);
        end else begin
            step_new = quot;
        end
    end

    assign s       = i_ctrl.retarget ? step_new : i_step;
    assign o_step  = s;
    assign twice_s = {s, 1'b0};
    // Within two steps of the target the channel lands on it.
    assign snap    = {1'b0, span} < twice_s;
    assign o_moved = i_ctrl.active && (above || below);

    always_comb begin
        if (!i_ctrl.active) begin
            o_cur = i_cur;
        end else if (above) begin
            o_cur = snap ? i_tgt : (i_cur - s);
        end else if (below) begin
            o_cur = snap ? i_tgt : (i_cur + s);
        end else begin
            o_cur = i_cur;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dual_motor_duty_ramp.sv
// Path: a result item passes through the input register, then the state and result
// register; a stall on the result side can hold it in the input register.
// Throughput: one item per cycle, sustained while the result side takes items.
// Reset: synchronous, active low; ramp state, speed settings and handshakes clear
// at once, so the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_duty_ramp #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dmdr_in_if.sink     i_in_ch,
    dmdr_out_if.source  o_out_ch,
    dmdr_cfg_if.sink    i_cfg_ch
);

    localparam int NCH = dmdr_pkg::NCHAN;

    // ------------------------------------------------------------------
    // Pipeline handshake. Stage one is the input register; the state
    // registers double as the result register, since the state only
    // changes when an item moves into the result slot, and that slot is
    // free (or being emptied) whenever that happens.
    // ------------------------------------------------------------------
    logic       r_s1_valid;
    logic [1:0] r_func;
    logic [3:0] r_value;
    logic       r_out_valid;
    logic       s2_ready;
    logic       advance;

    assign s2_ready      = !r_out_valid || o_out_ch.ready;
    assign advance       = r_s1_valid && s2_ready;
    assign i_in_ch.ready = !r_s1_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_func  <= i_in_ch.func;
            r_value <= i_in_ch.value;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; writes to an index beyond
    // the three level duties are taken and dropped.
    // ------------------------------------------------------------------
    logic [DUTY_BITS-1:0] r_slow_duty;
    logic [DUTY_BITS-1:0] r_middle_duty;
    logic [DUTY_BITS-1:0] r_fast_duty;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_duty   <= DUTY_BITS'(dmdr_pkg::SLOW_RESET);
            r_middle_duty <= DUTY_BITS'(dmdr_pkg::MIDDLE_RESET);
            r_fast_duty   <= DUTY_BITS'(dmdr_pkg::FAST_RESET);
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                dmdr_pkg::CFG_SLOW:   r_slow_duty   <= i_cfg_ch.data;
                dmdr_pkg::CFG_MIDDLE: r_middle_duty <= i_cfg_ch.data;
                dmdr_pkg::CFG_FAST:   r_fast_duty   <= i_cfg_ch.data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ramp state.
    // ------------------------------------------------------------------
    logic                 r_pending, n_pending;
    logic                 r_active,  n_active;
    logic                 r_run,     n_run;
    logic [3:0]           r_dir,     n_dir;
    logic [1:0]           r_level,   n_level;
    logic [DUTY_BITS-1:0] r_level_duty, n_level_duty;
    logic [DUTY_BITS-1:0] r_cur  [NCH];
    logic [DUTY_BITS-1:0] r_tgt  [NCH];
    logic [DUTY_BITS-1:0] r_step [NCH];
    logic [DUTY_BITS-1:0] n_cur  [NCH];
    logic [DUTY_BITS-1:0] n_tgt  [NCH];
    logic [DUTY_BITS-1:0] n_step [NCH];

    // Targets from the present direction, level duty and on state; a tick
    // does not change any of those, so they are read straight from state.
    logic [DUTY_BITS-1:0] new_tgt  [NCH];
    logic [DUTY_BITS-1:0] eff_tgt  [NCH];
    logic [DUTY_BITS-1:0] chan_cur [NCH];
    logic [DUTY_BITS-1:0] chan_step[NCH];
    logic [NCH-1:0]       chan_moved;
    dmdr_pkg::t_chan_ctrl ctrl;

    dmdr_target #(
        .DUTY_BITS (DUTY_BITS)
    ) u_target (
        .i_run        (r_run),
        .i_dir        (r_dir),
        .i_level_duty (r_level_duty),
        .o_tgt        (new_tgt)
    );

    // A pending retarget starts (or restarts) the ramp on this tick.
    assign ctrl.retarget = r_pending;
    assign ctrl.active   = r_pending || r_active;

    for (genvar g = 0; g < NCH; g++) begin : g_chan
        assign eff_tgt[g] = r_pending ? new_tgt[g] : r_tgt[g];

        dmdr_chan #(
            .DUTY_BITS (DUTY_BITS)
        ) u_chan (
            .i_ctrl  (ctrl),
            .i_cur   (r_cur[g]),
            .i_tgt   (eff_tgt[g]),
            .i_step  (r_step[g]),
            .o_cur   (chan_cur[g]),
            .o_step  (chan_step[g]),
            .o_moved (chan_moved[g])
        );
    end

    // Level duty picked by a level code; the keep code leaves it alone.
    function automatic logic [DUTY_BITS-1:0] pick_duty(
        input logic [1:0]           level,
        input logic [DUTY_BITS-1:0] keep,
        input logic [DUTY_BITS-1:0] slow,
        input logic [DUTY_BITS-1:0] middle,
        input logic [DUTY_BITS-1:0] fast
    );
        logic [DUTY_BITS-1:0] d;
        case (level)
            dmdr_pkg::SPEED_SLOW:   d = slow;
            dmdr_pkg::SPEED_MIDDLE: d = middle;
            dmdr_pkg::SPEED_FAST:   d = fast;
            default:                d = keep;
        endcase
        return d;
    endfunction

    always_comb begin
        n_pending    = r_pending;
        n_active     = r_active;
        n_run        = r_run;
        n_dir        = r_dir;
        n_level      = r_level;
        n_level_duty = r_level_duty;
        for (int i = 0; i < NCH; i++) begin
            n_cur[i]  = r_cur[i];
            n_tgt[i]  = r_tgt[i];
            n_step[i] = r_step[i];
        end
        case (dmdr_pkg::t_func'(r_func))
            dmdr_pkg::FUNC_TICK: begin
                n_pending = 1'b0;
                // The ramp ends on the tick that finds every channel settled.
                n_active  = ctrl.active && (|chan_moved);
                for (int i = 0; i < NCH; i++) begin
                    n_cur[i]  = chan_cur[i];
                    n_tgt[i]  = eff_tgt[i];
                    n_step[i] = chan_step[i];
                end
            end
            dmdr_pkg::FUNC_SPEED: begin
                n_level = r_value[1:0];
                if (r_value[3:2] == 2'b00 && r_run) begin
                    n_level_duty = pick_duty(r_value[1:0], r_level_duty,
                                             r_slow_duty, r_middle_duty, r_fast_duty);
                    n_pending    = 1'b1;
                end
                // Codes above the keep code are ignored altogether.
                if (r_value[3:2] != 2'b00) begin
                    n_level = r_level;
                end
            end
            dmdr_pkg::FUNC_DIR: begin
                if (r_value <= dmdr_pkg::DIR_BACK_LEFT) begin
                    n_dir = r_value;
                    if (r_run) begin
                        n_pending = 1'b1;
                    end
                end
            end
            dmdr_pkg::FUNC_POWER: begin
                if (r_value == dmdr_pkg::POWER_ON) begin
                    n_run        = 1'b1;
                    n_level_duty = pick_duty(r_level, r_level_duty,
                                             r_slow_duty, r_middle_duty, r_fast_duty);
                end else begin
                    // Anything but the on code switches off and stops.
                    n_run = 1'b0;
                    n_dir = dmdr_pkg::DIR_STOP;
                end
                n_pending = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b1;
            r_active     <= 1'b0;
            r_run        <= 1'b0;
            r_dir        <= dmdr_pkg::DIR_STOP;
            r_level      <= dmdr_pkg::SPEED_SLOW;
            r_level_duty <= DUTY_BITS'(dmdr_pkg::SLOW_RESET);
            for (int i = 0; i < NCH; i++) begin
                r_cur[i]  <= '0;
                r_tgt[i]  <= '0;
                r_step[i] <= '0;
            end
        end else if (advance) begin
            r_pending    <= n_pending;
            r_active     <= n_active;
            r_run        <= n_run;
            r_dir        <= n_dir;
            r_level      <= n_level;
            r_level_duty <= n_level_duty;
            for (int i = 0; i < NCH; i++) begin
                r_cur[i]  <= n_cur[i];
                r_tgt[i]  <= n_tgt[i];
                r_step[i] <= n_step[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result item: the state after the item, held while the sink stalls.
    // ------------------------------------------------------------------
    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.duty_fwd_a      = r_cur[dmdr_pkg::CH_FWD_A];
    assign o_out_ch.duty_fwd_b      = r_cur[dmdr_pkg::CH_FWD_B];
    assign o_out_ch.duty_back_a     = r_cur[dmdr_pkg::CH_BACK_A];
    assign o_out_ch.duty_back_b     = r_cur[dmdr_pkg::CH_BACK_B];
    assign o_out_ch.busy_ramping    = r_active;
    assign o_out_ch.drive_direction = r_dir;
    assign o_out_ch.level_now       = r_level;
    assign o_out_ch.is_on           = r_run;

endmodule

`default_nettype wire

>>> hw/rtl/dmdr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dmdr_checker #(
    parameter int DUTY_BITS = 13
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [DUTY_BITS-1:0] i_duty_fwd_a,
    input wire logic [DUTY_BITS-1:0] i_duty_fwd_b,
    input wire logic [DUTY_BITS-1:0] i_duty_back_a,
    input wire logic [DUTY_BITS-1:0] i_duty_back_b,
    input wire logic                 i_busy
);

    logic                 in_acc;
    logic                 out_acc;
    logic [1:0]           r_cnt;
    logic                 r_have_prev;
    logic [DUTY_BITS-1:0] r_prev [4];

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (in_acc && !out_acc) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!in_acc && out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (out_acc) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev[0] <= i_duty_fwd_a;
            r_prev[1] <= i_duty_fwd_b;
            r_prev[2] <= i_duty_back_a;
            r_prev[3] <= i_duty_back_b;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty_fwd_a)
            && $stable(i_duty_fwd_b) && $stable(i_duty_back_a) && $stable(i_duty_back_b))
        else $error("stalled result changed or vanished");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2) && (!i_out_valid || r_cnt != 2'd0))
        else $error("result without an item, or too many items in flight");

    a_idle_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !i_busy && r_have_prev |-> i_duty_fwd_a == r_prev[0]
            && i_duty_fwd_b == r_prev[1] && i_duty_back_a == r_prev[2]
            && i_duty_back_b == r_prev[3])
        else $error("duties moved while no ramp was running");

endmodule

bind dual_motor_duty_ramp dmdr_checker #(
    .DUTY_BITS (DUTY_BITS)
) u_dmdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_ch.valid),
    .i_in_ready    (i_in_ch.ready),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_duty_fwd_a  (o_out_ch.duty_fwd_a),
    .i_duty_fwd_b  (o_out_ch.duty_fwd_b),
    .i_duty_back_a (o_out_ch.duty_back_a),
    .i_duty_back_b (o_out_ch.duty_back_b),
    .i_busy        (o_out_ch.busy_ramping)
);

`default_nettype wire
